### sv/qra_pkg.sv
package qra_pkg;

    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [15:0] DEG_FULL    = 16'd46080;
    localparam logic [15:0] ANGLE_MAX   = 16'd51472;
    localparam int          CORDIC_STEPS = 30;

    localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
        32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536,
        32'd32768, 32'd16384, 32'd8192, 32'd4096, 32'd2048,
        32'd1024, 32'd512, 32'd256, 32'd128, 32'd64,
        32'd32, 32'd16, 32'd8, 32'd4, 32'd2
    };

    typedef enum logic [0:0] {
        REG_UNIT_SELECT = 1'b0
    } reg_index_t;

    typedef struct packed {
        logic signed [15:0] a_w;
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] b_w;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
    } quat_t;

    typedef struct packed {
        logic [15:0] angle;
        logic        zero_magnitude;
    } result_t;

endpackage

### sv/qra_pipe.sv
module qra_pipe (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  qra_pkg::quat_t in_item,
    input  logic           unit_sel,
    output logic           out_valid,
    output qra_pkg::result_t out_item
);
    import qra_pkg::*;

    localparam int SQ_STEPS = 63;
    localparam int NM_STEPS = 6;
    localparam int DEPTH    = 7 + SQ_STEPS + 1 + NM_STEPS + 1 + CORDIC_STEPS + 5;

    localparam logic [16:0] RECIP_PI = 17'((64'd1 << 48) / 64'(PI_Q30));
    localparam logic [33:0] PI2_Q30  = 34'(PI_Q30) << 1;

    typedef enum logic [1:0] {
        KIND_NORMAL,
        KIND_FLAT,
        KIND_QUARTER,
        KIND_ZERO
    } kind_t;

    typedef struct packed {
        logic        neg;
        logic        zero;
        logic        dmz;
        logic [32:0] dm;
    } hdr_t;

    typedef struct packed {
        kind_t       kind;
        logic        neg;
        logic [32:0] dm;
    } sq_tag_t;

    typedef struct packed {
        kind_t kind;
        logic  neg;
    } c_tag_t;

    logic [DEPTH:1] valid_reg;

    logic signed [15:0] qa [4];
    logic signed [15:0] qb [4];
    logic signed [31:0] aa_reg [4];
    logic signed [31:0] bb_reg [4];
    logic signed [31:0] ab_reg [4];

    logic [32:0]        na2_reg;
    logic [32:0]        nb2_reg;
    logic signed [33:0] dot2_reg;

    logic [32:0] na3_reg;
    logic [32:0] nb3_reg;
    hdr_t        hdr3_reg;

    logic [65:0] p4_reg;
    logic [65:0] dm2_4_reg;
    logic [32:0] na4_reg;
    hdr_t        hdr4_reg;

    logic [65:0] plo5_reg;
    logic [65:0] phi5_reg;
    logic [96:0] q5_reg;
    hdr_t        hdr5_reg;

    logic [96:0] big6_reg;
    logic [96:0] q6_reg;
    hdr_t        hdr6_reg;

    logic [97:0] sub_next;
    logic        lt_next;
    kind_t       kind7_next;

    logic [125:0] sq_v_reg   [0:SQ_STEPS-1];
    logic [64:0]  sq_r_reg   [0:SQ_STEPS-1];
    logic [62:0]  sq_q_reg   [0:SQ_STEPS];
    sq_tag_t      sq_tag_reg [0:SQ_STEPS];

    logic [63:0] mx_next;
    logic [63:0] my_next;
    c_tag_t      mtag_next;

    logic [63:0] nm_m_reg   [0:NM_STEPS-1];
    logic [63:0] nm_x_reg   [0:NM_STEPS];
    logic [63:0] nm_y_reg   [0:NM_STEPS];
    c_tag_t      nm_tag_reg [0:NM_STEPS];

    logic signed [42:0] cx_reg   [0:CORDIC_STEPS-1];
    logic signed [42:0] cy_reg   [0:CORDIC_STEPS-1];
    logic signed [32:0] cz_reg   [0:CORDIC_STEPS];
    c_tag_t             ctag_reg [0:CORDIC_STEPS];

    logic [31:0] hclamp_next;
    logic [31:0] hsel_next;
    logic [31:0] half_reg;
    logic        hzero_reg;

    logic [47:0] dnum1_reg;
    logic [15:0] drad1_reg;
    logic        dzero1_reg;
    logic [15:0] dqe2_reg;
    logic [47:0] dnum2_reg;
    logic [15:0] drad2_reg;
    logic        dzero2_reg;
    logic [33:0] drem3_reg;
    logic [15:0] dqe3_reg;
    logic [15:0] drad3_reg;
    logic        dzero3_reg;
    logic [15:0] deg_next;
    logic [15:0] deg4_reg;
    logic [15:0] drad4_reg;
    logic        dzero4_reg;

    // valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DEPTH-1:1], in_valid};
        end
    end

    always_comb
    begin
        qa[0] = in_item.a_w;
        qa[1] = in_item.a_x;
        qa[2] = in_item.a_y;
        qa[3] = in_item.a_z;
        qb[0] = in_item.b_w;
        qb[1] = in_item.b_x;
        qb[2] = in_item.b_y;
        qb[3] = in_item.b_z;
    end

    // products, sums, magnitude of the dot product, |a|^4*|b|^2 and the scaled square of the dot product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                aa_reg[i] <= qa[i] * qa[i];
                bb_reg[i] <= qb[i] * qb[i];
                ab_reg[i] <= qa[i] * qb[i];
            end
            na2_reg  <= 33'(aa_reg[0][30:0]) + 33'(aa_reg[1][30:0])
                      + 33'(aa_reg[2][30:0]) + 33'(aa_reg[3][30:0]);
            nb2_reg  <= 33'(bb_reg[0][30:0]) + 33'(bb_reg[1][30:0])
                      + 33'(bb_reg[2][30:0]) + 33'(bb_reg[3][30:0]);
            dot2_reg <= 34'(ab_reg[0]) + 34'(ab_reg[1]) + 34'(ab_reg[2]) + 34'(ab_reg[3]);

            na3_reg       <= na2_reg;
            nb3_reg       <= nb2_reg;
            hdr3_reg.neg  <= dot2_reg[33];
            hdr3_reg.zero <= (na2_reg == '0) || (nb2_reg == '0);
            hdr3_reg.dmz  <= (dot2_reg == '0);
            hdr3_reg.dm   <= dot2_reg[33] ? 33'(-dot2_reg) : 33'(dot2_reg);

            p4_reg    <= na3_reg * nb3_reg;
            dm2_4_reg <= hdr3_reg.dm * hdr3_reg.dm;
            na4_reg   <= na3_reg;
            hdr4_reg  <= hdr3_reg;

            plo5_reg <= na4_reg * p4_reg[32:0];
            phi5_reg <= na4_reg * p4_reg[65:33];
            q5_reg   <= 97'(dm2_4_reg) << 28;
            hdr5_reg <= hdr4_reg;

            big6_reg <= 97'(plo5_reg) + (97'(phi5_reg) << 33);
            q6_reg   <= q5_reg;
            hdr6_reg <= hdr5_reg;
        end
    end

    // compare cos^2 against one, pick the special cases
    always_comb
    begin
        sub_next = {1'b0, big6_reg} - {1'b0, q6_reg};
        lt_next  = !sub_next[97] && (sub_next[96:0] != '0);
        priority if (hdr6_reg.zero)
            kind7_next = KIND_ZERO;
        else if (hdr6_reg.dmz)
            kind7_next = KIND_QUARTER;
        else if (!lt_next)
            kind7_next = KIND_FLAT;
        else
            kind7_next = KIND_NORMAL;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_v_reg[0]        <= {1'b0, sub_next[96:0], 28'b0};
            sq_r_reg[0]        <= '0;
            sq_q_reg[0]        <= '0;
            sq_tag_reg[0].kind <= kind7_next;
            sq_tag_reg[0].neg  <= hdr6_reg.neg;
            sq_tag_reg[0].dm   <= hdr6_reg.dm;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        logic [66:0] r2_next;
        logic [66:0] t_next;
        logic        ge_next;

        always_comb
        begin
            r2_next = {sq_r_reg[k], sq_v_reg[k][125:124]};
            t_next  = {2'b00, sq_q_reg[k], 2'b01};
            ge_next = (r2_next >= t_next);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_q_reg[k+1]   <= {sq_q_reg[k][61:0], ge_next};
                sq_tag_reg[k+1] <= sq_tag_reg[k];
            end
        end

        if (k < SQ_STEPS - 1)
        begin : g_shift
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_r_reg[k+1] <= ge_next ? 65'(r2_next - t_next) : 65'(r2_next);
                    sq_v_reg[k+1] <= {sq_v_reg[k][123:0], 2'b00};
                end
            end
        end
    end

    always_comb
    begin
        mx_next        = {3'b000, sq_tag_reg[SQ_STEPS].dm, 28'b0};
        my_next        = {1'b0, sq_q_reg[SQ_STEPS]};
        mtag_next.neg  = sq_tag_reg[SQ_STEPS].neg;
        mtag_next.kind = sq_tag_reg[SQ_STEPS].kind;
        if (sq_tag_reg[SQ_STEPS].kind == KIND_NORMAL && sq_q_reg[SQ_STEPS] == '0)
        begin
            mtag_next.kind = KIND_FLAT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_m_reg[0]   <= (mx_next > my_next) ? mx_next : my_next;
            nm_x_reg[0]   <= mx_next;
            nm_y_reg[0]   <= my_next;
            nm_tag_reg[0] <= mtag_next;
        end
    end

    // normalize so the larger leg has its top bit at 63
    for (genvar j = 0; j < NM_STEPS; j++)
    begin : g_norm
        localparam int S = 32 >> j;
        logic sh_next;

        assign sh_next = (nm_m_reg[j][63 -: S] == '0);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nm_x_reg[j+1]   <= sh_next ? (nm_x_reg[j] << S) : nm_x_reg[j];
                nm_y_reg[j+1]   <= sh_next ? (nm_y_reg[j] << S) : nm_y_reg[j];
                nm_tag_reg[j+1] <= nm_tag_reg[j];
            end
        end

        if (j < NM_STEPS - 1)
        begin : g_m
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nm_m_reg[j+1] <= sh_next ? (nm_m_reg[j] << S) : nm_m_reg[j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0]   <= {3'b000, nm_x_reg[NM_STEPS][63:24]};
            cy_reg[0]   <= {3'b000, nm_y_reg[NM_STEPS][63:24]};
            cz_reg[0]   <= '0;
            ctag_reg[0] <= nm_tag_reg[NM_STEPS];
        end
    end

    // vectoring cordic
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        localparam logic signed [32:0] ATAN_I = 33'(ATAN_Q30[i]);
        logic signed [42:0] xs_next;
        logic signed [42:0] ys_next;
        logic               pos_next;

        always_comb
        begin
            xs_next  = cx_reg[i] >>> i;
            ys_next  = cy_reg[i] >>> i;
            pos_next = (cy_reg[i] > 43'sd0);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cz_reg[i+1]   <= pos_next ? cz_reg[i] + ATAN_I : cz_reg[i] - ATAN_I;
                ctag_reg[i+1] <= ctag_reg[i];
            end
        end

        if (i < CORDIC_STEPS - 1)
        begin : g_xy
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    cx_reg[i+1] <= pos_next ? cx_reg[i] + ys_next : cx_reg[i] - ys_next;
                    cy_reg[i+1] <= pos_next ? cy_reg[i] - xs_next : cy_reg[i] + xs_next;
                end
            end
        end
    end

    // clamp, special cases, reflect for a negative dot product
    always_comb
    begin
        priority if (cz_reg[CORDIC_STEPS] < 33'sd0)
            hclamp_next = '0;
        else if (cz_reg[CORDIC_STEPS] > $signed(33'(HALF_PI_Q30)))
            hclamp_next = HALF_PI_Q30;
        else
            hclamp_next = 32'(cz_reg[CORDIC_STEPS]);

        unique case (ctag_reg[CORDIC_STEPS].kind)
            KIND_NORMAL:  hsel_next = hclamp_next;
            KIND_QUARTER: hsel_next = HALF_PI_Q30;
            default:      hsel_next = '0;
        endcase

        if (ctag_reg[CORDIC_STEPS].neg)
        begin
            hsel_next = PI_Q30 - hsel_next;
        end
    end

    // divide by pi: reciprocal estimate, remainder, then up to two corrections
    always_comb
    begin
        priority if (drem3_reg >= PI2_Q30)
            deg_next = dqe3_reg + 16'd2;
        else if (drem3_reg >= 34'(PI_Q30))
            deg_next = dqe3_reg + 16'd1;
        else
            deg_next = dqe3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            half_reg  <= hsel_next;
            hzero_reg <= (ctag_reg[CORDIC_STEPS].kind == KIND_ZERO);

            dnum1_reg  <= 48'(half_reg) * 48'(DEG_FULL) + 48'(PI_Q30 / 2);
            drad1_reg  <= 16'((33'(half_reg) + 33'd32768) >> 16);
            dzero1_reg <= hzero_reg;

            dqe2_reg   <= 16'((48'(dnum1_reg[47:16]) * 48'(RECIP_PI)) >> 32);
            dnum2_reg  <= dnum1_reg;
            drad2_reg  <= drad1_reg;
            dzero2_reg <= dzero1_reg;

            drem3_reg  <= 34'(dnum2_reg - 48'(dqe2_reg) * 48'(PI_Q30));
            dqe3_reg   <= dqe2_reg;
            drad3_reg  <= drad2_reg;
            dzero3_reg <= dzero2_reg;

            deg4_reg   <= deg_next;
            drad4_reg  <= drad3_reg;
            dzero4_reg <= dzero3_reg;
        end
    end

    always_comb
    begin
        out_valid               = valid_reg[DEPTH];
        out_item.zero_magnitude = dzero4_reg;
        if (dzero4_reg)
            out_item.angle = '0;
        else if (unit_sel)
            out_item.angle = deg4_reg;
        else
            out_item.angle = drad4_reg;
    end

endmodule

### sv/quaternion_relative_angle_top.sv
// Relative rotation angle between two orientations given as quaternions a and b
// (components signed Q1.14): angle = 2*acos(clamp(dot(a,b)/(|a|^2*|b|), -1, 1)),
// returned in radians Q3.13 or in degrees Q9.7 as chosen by unit_select (APB
// byte address 0, bit 0, reset 0). If either quaternion is all zero the angle
// is 0 and zero_magnitude is set. One item is taken every clock cycle while
// quat_stall is low; each result passes through a pipeline made up mostly of
// the 63-stage square root and the 30-stage CORDIC before it is presented.
// While the output stalls the pipeline keeps moving until a result finds the
// output register full; that result waits in a one-entry skid buffer and
// quat_stall is high for as long as the buffer holds it.
module quaternion_relative_angle_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             quat_valid,
    output logic             quat_stall,
    input  qra_pkg::quat_t   quat,
    output logic             angle_valid,
    input  logic             angle_stall,
    output qra_pkg::result_t result
);
    import qra_pkg::*;

    logic    unit_sel_reg;
    logic    en;
    logic    pipe_valid;
    result_t pipe_item;

    logic    res_valid_reg;
    logic    res_valid_next;
    result_t res_reg;
    result_t res_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_reg;
    result_t skid_next;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_sel_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_UNIT_SELECT)
        begin
            unit_sel_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_UNIT_SELECT)
        begin
            prdata[0] = unit_sel_reg;
        end
    end

    assign en         = !skid_valid_reg;
    assign quat_stall = skid_valid_reg;

    qra_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (quat_valid),
        .in_item   (quat),
        .unit_sel  (unit_sel_reg),
        .out_valid (pipe_valid),
        .out_item  (pipe_item)
    );

    always_comb
    begin
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!res_valid_reg || !angle_stall)
        begin
            if (skid_valid_reg)
            begin
                res_valid_next  = 1'b1;
                res_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                res_valid_next = pipe_valid;
                res_next       = pipe_item;
            end
        end
        else if (pipe_valid && !skid_valid_reg)
        begin
            skid_valid_next = 1'b1;
            skid_next       = pipe_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg  <= res_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        skid_reg <= skid_next;
    end

    assign angle_valid = res_valid_reg;
    assign result      = res_reg;

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(res_valid_reg && angle_stall))
        else $error("skid filled while output was free");

    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (angle_valid && result.zero_magnitude) |-> (result.angle == '0))
        else $error("zero magnitude with nonzero angle");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid |-> (result.angle <= ANGLE_MAX))
        else $error("angle out of range");

endmodule
